[design/qts_pkg.sv]
// ----------------------------------------------------------------------------
// qts_pkg
// Shared types, constants and helpers of the quoted token splitter.
// ----------------------------------------------------------------------------
package qts_pkg;

    // String and token limits
    localparam int MAX_STRING_LEN   = 4096;
    localparam int MAX_TOKENS_LIMIT = 64;
    localparam int OFF_W            = $clog2(MAX_STRING_LEN + 1);
    localparam int SEEN_W           = 7;

    // Result queue depth
    localparam int QDEPTH = 4;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Configuration register indexes
    localparam logic [1:0] CFG_SEP_MODE   = 2'd0;
    localparam logic [1:0] CFG_SEP_CHAR   = 2'd1;
    localparam logic [1:0] CFG_MAX_TOKENS = 2'd2;

    // Reset values of the configuration registers
    localparam logic       RST_SEP_MODE   = 1'b0;
    localparam logic [7:0] RST_SEP_CHAR   = 8'd44;
    localparam logic [6:0] RST_MAX_TOKENS = 7'd64;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TOO_MANY   = 2'd1;
    localparam logic [1:0] ST_UNMATCHED  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG   = 2'd3;

    // Result kinds
    localparam logic KIND_TOKEN   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Scanner state
    typedef enum logic [3:0] {
        S_SKIP   = 4'b0001,
        S_PLAIN  = 4'b0010,
        S_QUOTED = 4'b0100,
        S_DRAIN  = 4'b1000
    } t_scan_mode;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic        item_kind;
        logic [11:0] token_start;
        logic [12:0] token_length;
        logic [5:0]  token_index;
        logic        was_quoted;
        logic [6:0]  token_total;
        logic [1:0]  status;
        logic        last_of_run;
    } t_out_item;

    // Results of one beat pushed into the queue
    typedef struct packed {
        logic [1:0] count;
        t_out_item  r0;
        t_out_item  r1;
    } t_res_push;

    // Queue status back to the scanner
    typedef struct packed {
        logic              space_ok;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

    function automatic logic is_sep(input logic mode, input logic [7:0] sep_char,
                                    input logic [7:0] b);
        logic r;
        if (mode) begin
            r = (b == sep_char);
        end else begin
            r = (b == CH_SPACE) || (b == CH_TAB);
        end
        return r;
    endfunction

endpackage

[design/qts_scan.sv]
// ----------------------------------------------------------------------------
// qts_scan
// Input register, configuration registers and the per-beat scanner update.
// Produces up to two results (token, summary) per input beat.
// ----------------------------------------------------------------------------
module qts_scan import qts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  t_q_stat    i_q_stat,
    output t_res_push  o_push
);

    // Configuration
    logic       r_sep_mode;
    logic [7:0] r_sep_char;
    logic [6:0] r_max_tokens;

    // Input register
    logic     r_in_valid, n_in_valid;
    t_in_item r_in;

    // Scanner state
    t_scan_mode        r_mode, n_mode;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [OFF_W-1:0]  r_start, n_start;
    logic [SEEN_W-1:0] r_seen, n_seen;
    logic [1:0]        r_err, n_err;

    logic advance, accept;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && i_q_stat.space_ok;
    assign o_in_stall  = r_in_valid && !advance;
    assign accept      = i_in_valid && !o_in_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_mode   <= RST_SEP_MODE;
            r_sep_char   <= RST_SEP_CHAR;
            r_max_tokens <= RST_MAX_TOKENS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SEP_MODE:   r_sep_mode   <= i_cfg_data[0];
                CFG_SEP_CHAR:   r_sep_char   <= i_cfg_data;
                CFG_MAX_TOKENS: r_max_tokens <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    // Scanner update for the registered beat
    always_comb begin
        logic [SEEN_W-1:0] limit;
        logic              sep;
        logic              tok_v;
        logic [OFF_W-1:0]  tok_end;
        logic              tok_q;
        logic [OFF_W-1:0]  tok_len;
        t_out_item         tok, summ;

        n_mode  = r_mode;
        n_off   = r_off;
        n_start = r_start;
        n_seen  = r_seen;
        n_err   = r_err;
        tok_v   = 1'b0;
        tok_end = r_off;
        tok_q   = 1'b0;
        tok_len = '0;
        tok     = '0;
        summ    = '0;
        o_push  = '0;

        limit = (r_max_tokens < SEEN_W'(MAX_TOKENS_LIMIT)) ? r_max_tokens
                                                          : SEEN_W'(MAX_TOKENS_LIMIT);
        sep   = is_sep(r_sep_mode, r_sep_char, r_in.data_byte);

        if (advance) begin
            // byte handling
            if (r_in.byte_present && (r_err == ST_OK)) begin
                if (r_off >= OFF_W'(MAX_STRING_LEN)) begin
                    n_off  = OFF_W'(MAX_STRING_LEN);
                    n_err  = ST_TOO_LONG;
                    n_mode = S_DRAIN;
                end else begin
                    unique case (r_mode)
                        S_SKIP: begin
                            if (!sep) begin
                                if (r_seen >= limit) begin
                                    n_err  = ST_TOO_MANY;
                                    n_mode = S_DRAIN;
                                end else if (r_in.data_byte == CH_QUOTE) begin
                                    n_start = r_off + OFF_W'(1);
                                    n_mode  = S_QUOTED;
                                end else begin
                                    n_start = r_off;
                                    n_mode  = S_PLAIN;
                                end
                            end
                        end
                        S_PLAIN: begin
                            if (sep) begin
                                tok_v   = 1'b1;
                                tok_end = r_off;
                                n_mode  = S_SKIP;
                            end
                        end
                        S_QUOTED: begin
                            if (r_in.data_byte == CH_QUOTE) begin
                                tok_v   = 1'b1;
                                tok_q   = 1'b1;
                                tok_end = r_off;
                                n_mode  = S_SKIP;
                            end
                        end
                        S_DRAIN: ;
                        default: ;
                    endcase
                    if (n_err == ST_OK) begin
                        n_off = r_off + OFF_W'(1);
                    end
                end
            end

            // end of string: close an open plain token, flag an open quoted one
            if (r_in.end_of_string && (n_err == ST_OK)) begin
                if (n_mode == S_PLAIN) begin
                    tok_v   = 1'b1;
                    tok_end = n_off;
                end else if (n_mode == S_QUOTED) begin
                    n_err = ST_UNMATCHED;
                end
            end

            // token result
            tok_len           = (tok_end >= n_start) ? (tok_end - n_start) : '0;
            tok.item_kind     = KIND_TOKEN;
            tok.token_start   = n_start[11:0];
            tok.token_length  = tok_len[12:0];
            tok.token_index   = r_seen[5:0];
            tok.was_quoted    = tok_q;
            tok.token_total   = r_seen + SEEN_W'(1);
            tok.status        = ST_OK;
            tok.last_of_run   = !r_in.end_of_string;
            if (tok_v) begin
                n_seen = r_seen + SEEN_W'(1);
            end

            // summary result
            summ.item_kind   = KIND_SUMMARY;
            summ.token_total = n_seen;
            summ.status      = n_err;
            summ.last_of_run = 1'b1;

            o_push.count = {1'b0, tok_v} + {1'b0, r_in.end_of_string};
            o_push.r0    = tok_v ? tok : summ;
            o_push.r1    = summ;

            // clear per-string state after the summary
            if (r_in.end_of_string) begin
                n_mode  = S_SKIP;
                n_off   = '0;
                n_start = '0;
                n_seen  = '0;
                n_err   = ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= S_SKIP;
            r_off   <= '0;
            r_start <= '0;
            r_seen  <= '0;
            r_err   <= ST_OK;
        end else begin
            r_mode  <= n_mode;
            r_off   <= n_off;
            r_start <= n_start;
            r_seen  <= n_seen;
            r_err   <= n_err;
        end
    end

endmodule

[design/qts_outq.sv]
// ----------------------------------------------------------------------------
// qts_outq
// Shifting result queue. Takes up to two results per beat, hands out one.
// Entry 0 is the head and drives the output port.
// ----------------------------------------------------------------------------
module qts_outq import qts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_res_push i_push,
    output t_q_stat   o_q_stat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_out_item         r_q [QDEPTH];
    t_out_item         n_q [QDEPTH];
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic [QCNT_W-1:0] cnt_after_pop;
    logic              pop;

    assign o_out_valid       = (r_cnt != '0);
    assign o_out_data        = r_q[0];
    assign pop               = o_out_valid && !i_out_stall;
    assign o_q_stat.space_ok = (r_cnt <= QCNT_W'(QDEPTH - 2));
    assign o_q_stat.count    = r_cnt;

    // shift on pop, append pushed results behind the survivors
    always_comb begin
        cnt_after_pop = r_cnt - QCNT_W'(pop);
        for (int i = 0; i < QDEPTH; i++) begin
            if (pop && (i < QDEPTH - 1)) begin
                n_q[i] = r_q[(i + 1) % QDEPTH];
            end else begin
                n_q[i] = r_q[i];
            end
            if ((i_push.count != 2'd0) && (cnt_after_pop == QCNT_W'(i))) begin
                n_q[i] = i_push.r0;
            end
            if ((i_push.count == 2'd2) && (cnt_after_pop + QCNT_W'(1) == QCNT_W'(i))) begin
                n_q[i] = i_push.r1;
            end
        end
        n_cnt = cnt_after_pop + QCNT_W'(i_push.count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule

[design/quoted_token_splitter_top.sv]
// Path: a beat's results pass the input register and then the result queue.
// Throughput: one input beat per cycle while each beat yields at most one result and
// the output is not stalled; a beat that yields a token and a summary takes an extra
// output slot, as the single-result output port drains the four-entry result queue.
// Reset: synchronous, active low; clears scanner state, queue and input register,
// and loads the configuration defaults (space/tab, comma, 64 tokens).
// ----------------------------------------------------------------------------
// quoted_token_splitter_top
// Splits a byte stream into plain and quoted tokens, one byte per beat, and
// reports every token plus an end-of-string summary.
// ----------------------------------------------------------------------------
module quoted_token_splitter_top import qts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_res_push push;
    t_q_stat   q_stat;

    // Scanner
    qts_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (q_stat),
        .o_push      (push)
    );

    // Result queue
    qts_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_q_stat    (q_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // no push without room for two results
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count != 2'd0) |-> q_stat.space_ok)
        else $error("result pushed into full queue");

    // queue never overflows
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= QCNT_W'(QDEPTH))
        else $error("result queue count out of range");

    // a double push is always token then summary
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count == 2'd2) |-> (push.r0.item_kind == KIND_TOKEN
                                  && push.r1.item_kind == KIND_SUMMARY))
        else $error("bad result pair order");

    // a summary always closes its run
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.item_kind == KIND_SUMMARY) |-> o_out_data.last_of_run)
        else $error("summary without last_of_run");
`endif

endmodule
